[src/gca_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gca_pkg
// Shared word type, operation codes, stage payloads and Gray code helpers
// for the Gray code arithmetic unit.
// ----------------------------------------------------------------------------
package gca_pkg;

  localparam int WORD_BITS = 32;
  localparam int OP_BITS   = 3;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [OP_BITS-1:0] {
    OP_ADD = 3'd0,
    OP_INC = 3'd1,
    OP_DEC = 3'd2,
    OP_MUL = 3'd3,
    OP_G2B = 3'd4,
    OP_B2G = 3'd5
  } op_t;

  // after decode: raw first operand kept for binary to gray
  typedef struct packed {
    op_t   op;
    word_t a_raw;
    word_t a_bin;
    word_t b_bin;
  } dec_t;

  // after arithmetic: binary result, still to be encoded
  typedef struct packed {
    op_t   op;
    word_t r_bin;
  } ari_t;

  // prefix xor from the top bit down, in log2 steps
  function automatic word_t gray2bin(input word_t g);
    word_t b;
    b = g;
    for (int s = 1; s < WORD_BITS; s = s * 2) begin
      b = b ^ (b >> s);
    end
    return b;
  endfunction

  function automatic word_t bin2gray(input word_t b);
    return b ^ (b >> 1);
  endfunction

endpackage

[src/gray_code_arithmetic_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gray_code_arithmetic_unit
// Stateless arithmetic on reflected Gray coded words: add, increment,
// decrement, multiply, gray to binary and binary to gray.
// ----------------------------------------------------------------------------
//
//  channel  dir  signals                      payload
//  -------  ---  ---------------------------  -------------------------------
//  s_       in   s_tvalid s_tready s_tdata    operand_a, operand_b
//                s_tuser                      operation
//  m_       out  m_tvalid m_tready m_tdata    result
//
//  three register stages: decode, arithmetic, encode; the last one is the
//  output register, so a result reaches m_tdata once it has passed the
//  decode, arithmetic and encode registers
//  one transaction per cycle sustained while m_tready is high; the 32x32
//  low-word multiplier in the arithmetic stage sets the clock
//  each stage holds its item while the next one is full and stalled, and
//  takes a new one as soon as its item moves on; nothing is lost or repeated
//  rst clears only the stage valid bits
//
module gray_code_arithmetic_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [2:0]  s_tuser,   // operation [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // result [31:0]
);

  // handshake between stages
  logic dec_valid;
  logic dec_ready;
  logic ari_valid;
  logic ari_ready;

  gca_pkg::dec_t  dec_data;
  gca_pkg::ari_t  ari_data;
  gca_pkg::word_t enc_data;

  // stage 1: gray operands to binary
  gca_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (gca_pkg::op_t'(s_tuser)),
    .in_a      (s_tdata[31:0]),
    .in_b      (s_tdata[63:32]),
    .out_valid (dec_valid),
    .out_ready (dec_ready),
    .out_data  (dec_data)
  );

  // stage 2: binary arithmetic modulo 2^32, conversions passed through
  gca_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dec_valid),
    .in_ready  (dec_ready),
    .in_data   (dec_data),
    .out_valid (ari_valid),
    .out_ready (ari_ready),
    .out_data  (ari_data)
  );

  // stage 3: back to gray, held in the output register
  gca_encode u_encode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ari_valid),
    .in_ready  (ari_ready),
    .in_data   (ari_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (enc_data)
  );

  assign m_tdata = enc_data;

endmodule

[src/gca_decode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gca_decode
// First pipeline stage: decodes both Gray operands to binary.
// ----------------------------------------------------------------------------
module gca_decode (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gca_pkg::op_t  in_op,
  input  gca_pkg::word_t in_a,
  input  gca_pkg::word_t in_b,
  output logic          out_valid,
  input  logic          out_ready,
  output gca_pkg::dec_t out_data
);

  logic          vld;
  gca_pkg::dec_t data;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.op    <= in_op;
      data.a_raw <= in_a;
      data.a_bin <= gca_pkg::gray2bin(in_a);
      data.b_bin <= gca_pkg::gray2bin(in_b);
    end
  end

endmodule

[src/gca_arith.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gca_arith
// Second pipeline stage: binary add, increment, decrement and multiply,
// all modulo 2^WORD_BITS; the conversions pass an operand through.
// ----------------------------------------------------------------------------
module gca_arith (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  gca_pkg::dec_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output gca_pkg::ari_t out_data
);

  logic           vld;
  gca_pkg::ari_t  data;
  gca_pkg::word_t r_bin;
  gca_pkg::word_t sum;
  gca_pkg::word_t prod;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  // one adder shared by add, increment and decrement
  always_comb begin
    case (in_data.op)
      gca_pkg::OP_INC: sum = in_data.a_bin + gca_pkg::word_t'(1);
      gca_pkg::OP_DEC: sum = in_data.a_bin - gca_pkg::word_t'(1);
      default:         sum = in_data.a_bin + in_data.b_bin;
    endcase
  end

  // low word of the product only
  assign prod = in_data.a_bin * in_data.b_bin;

  always_comb begin
    case (in_data.op)
      gca_pkg::OP_ADD,
      gca_pkg::OP_INC,
      gca_pkg::OP_DEC: r_bin = sum;
      gca_pkg::OP_MUL: r_bin = prod;
      gca_pkg::OP_G2B: r_bin = in_data.a_bin;
      gca_pkg::OP_B2G: r_bin = in_data.a_raw;
      default:         r_bin = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.op    <= in_data.op;
      data.r_bin <= r_bin;
    end
  end

endmodule

[src/gca_encode.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gca_encode
// Third pipeline stage and output register: encodes the binary result to
// Gray, passes it through for gray to binary, zero for unknown codes.
// ----------------------------------------------------------------------------
module gca_encode (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  gca_pkg::ari_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output gca_pkg::word_t out_data
);

  logic           vld;
  gca_pkg::word_t data;
  gca_pkg::word_t res;

  assign in_ready  = !vld || out_ready;
  assign out_valid = vld;
  assign out_data  = data;

  always_comb begin
    case (in_data.op)
      gca_pkg::OP_ADD,
      gca_pkg::OP_INC,
      gca_pkg::OP_DEC,
      gca_pkg::OP_MUL,
      gca_pkg::OP_B2G: res = gca_pkg::bin2gray(in_data.r_bin);
      gca_pkg::OP_G2B: res = in_data.r_bin;
      default:         res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= res;
    end
  end

endmodule
